// ===== hw/rtl/ptwa_pkg.sv =====
// Shared types and constants of the peer table with aging.
package ptwa_pkg;

  localparam logic [31:0] EXPIRY_RESET = 32'd10000;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPIRY_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    CMD_SEEN   = 2'd0,
    CMD_SWEEP  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_ADDED     = 3'd1,
    ST_SELF      = 3'd2,
    ST_FULL      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_SWEPT     = 3'd6
  } status_t;

  // Request carried down the cell row.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] addr;
    logic [31:0] now;
    logic [3:0]  pos;
  } req_t;

  // Fixed-width part of the token passed from cell to cell.
  typedef struct packed {
    req_t        req;
    logic        hit;
    logic        free_vld;
    logic [31:0] f_addr;
    logic [31:0] f_seen;
  } tok_t;

endpackage

// ===== hw/rtl/ptwa_cell.sv =====
// One peer slot: holds an entry and updates the token passing through it.
module ptwa_cell
  import ptwa_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   expiry_limit,
  input  logic          claim_vld,
  input  logic [IW-1:0] claim_idx,
  input  req_t          claim_req,
  input  logic          vld_in,
  input  tok_t          tok_in,
  input  logic [IW-1:0] idx_in,
  input  logic [CW-1:0] cnt_in,
  output logic          vld_out,
  output tok_t          tok_out,
  output logic [IW-1:0] idx_out,
  output logic [CW-1:0] cnt_out
);

  logic          active;
  logic [31:0]   addr_q;
  logic [31:0]   seen_q;

  tok_t          tok_next;
  logic [IW-1:0] idx_next;
  logic [CW-1:0] cnt_next;
  logic          refresh;
  logic          expire;
  logic          claim_hit;
  logic [CW+3:0] cnt_x;
  logic [CW+3:0] pos_x;

  assign claim_hit = claim_vld && (claim_idx == IW'(IDX));
  assign cnt_x     = {4'b0, cnt_in};
  assign pos_x     = {{CW{1'b0}}, tok_in.req.pos};

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    cnt_next = cnt_in;
    refresh  = 1'b0;
    expire   = 1'b0;
    if (vld_in) begin
      case (tok_in.req.cmd)
        CMD_SEEN: begin
          if (active && addr_q == tok_in.req.addr && !tok_in.hit) begin
            refresh      = 1'b1;
            tok_next.hit = 1'b1;
          end else if (!active && !tok_in.free_vld) begin
            // remember the lowest free slot
            tok_next.free_vld = 1'b1;
            idx_next          = IW'(IDX);
          end
        end
        CMD_SWEEP: begin
          if (active && (tok_in.req.now - seen_q) > expiry_limit) begin
            expire   = 1'b1;
            cnt_next = cnt_in + CW'(1);
          end
        end
        CMD_LOOKUP: begin
          if (active && !tok_in.hit) begin
            if (cnt_x == pos_x) begin
              tok_next.hit    = 1'b1;
              tok_next.f_addr = addr_q;
              tok_next.f_seen = seen_q;
            end else begin
              cnt_next = cnt_in + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
      if (claim_hit) begin
        active <= 1'b1;
      end else if (expire) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    idx_out <= idx_next;
    cnt_out <= cnt_next;
    if (claim_hit) begin
      addr_q <= claim_req.addr;
      seen_q <= claim_req.now;
    end else if (refresh) begin
      seen_q <= tok_in.req.now;
    end
  end

endmodule

// ===== hw/rtl/peer_table_with_aging_top.sv =====
// Top level of the peer table with aging: command control and the row of slot cells.
//
//   channel   direction  handshake                  payload
//   ------------------------------------------------------------------------------
//   command   in         start & !busy              command, peer_address, now, position
//   result    out        done (one-cycle strobe)    status, found_address, found_last_seen,
//                                                   active_count, expired_count
//   config    in         cfg_valid & cfg_ready      cfg_index, cfg_data
//
// A seen, sweep or lookup item walks the row of PEER_SLOTS cells, one cell per
// cycle, and the block takes no new item before its result; between acceptance
// and the strobe lie the launch register, the cells and the result registers. A
// seen item with the block's own address and the unused command answer in the next
// cycle and the block takes a new item at once. rst clears the active marks, both
// counts and registers. The receiver cannot stall: each result shows for one cycle.
module peer_table_with_aging_top
  import ptwa_pkg::*;
#(
  parameter int PEER_SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             command,
  input  logic [31:0]            peer_address,
  input  logic [31:0]            now,
  input  logic [3:0]             position,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output logic                   done,
  output logic [2:0]             status,
  output logic [31:0]            found_address,
  output logic [31:0]            found_last_seen,
  output logic [4:0]             active_count,
  output logic [4:0]             expired_count
);

  // slot index and count widths
  localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CW = $clog2(PEER_SLOTS + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t        state;
  logic [31:0]   local_address;
  logic [31:0]   expiry_limit;
  logic [CW-1:0] live;
  logic [CW-1:0] freed;
  logic          launch_vld;
  req_t          launch_req;

  // token row: entry 0 is the launch register, entry PEER_SLOTS the tail
  logic          tok_vld [0:PEER_SLOTS];
  tok_t          tok     [0:PEER_SLOTS];
  logic [IW-1:0] tok_idx [0:PEER_SLOTS];
  logic [CW-1:0] tok_cnt [0:PEER_SLOTS];

  logic          claim_vld;
  logic [CW+4:0] live_x;
  logic [CW+4:0] freed_x;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // low five bits of the counts
  assign live_x        = {5'b0, live};
  assign freed_x       = {5'b0, freed};
  assign active_count  = live_x[4:0];
  assign expired_count = freed_x[4:0];

  // Launch a fresh token into the first cell.
  assign tok_vld[0]          = launch_vld;
  assign tok[0].req          = launch_req;
  assign tok[0].hit          = 1'b0;
  assign tok[0].free_vld     = 1'b0;
  assign tok[0].f_addr       = 32'd0;
  assign tok[0].f_seen       = 32'd0;
  assign tok_idx[0]          = '0;
  assign tok_cnt[0]          = '0;

  // Claim the lowest free slot when a seen item found no match on its way down.
  assign claim_vld = tok_vld[PEER_SLOTS] && (tok[PEER_SLOTS].req.cmd == CMD_SEEN) &&
                     !tok[PEER_SLOTS].hit && tok[PEER_SLOTS].free_vld;

  for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_cell
    ptwa_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .expiry_limit (expiry_limit),
      .claim_vld    (claim_vld),
      .claim_idx    (tok_idx[PEER_SLOTS]),
      .claim_req    (tok[PEER_SLOTS].req),
      .vld_in       (tok_vld[i]),
      .tok_in       (tok[i]),
      .idx_in       (tok_idx[i]),
      .cnt_in       (tok_cnt[i]),
      .vld_out      (tok_vld[i+1]),
      .tok_out      (tok[i+1]),
      .idx_out      (tok_idx[i+1]),
      .cnt_out      (tok_cnt[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      launch_vld      <= 1'b0;
      live            <= '0;
      freed           <= '0;
      local_address   <= 32'd0;
      expiry_limit    <= EXPIRY_RESET;
      status          <= ST_NOT_FOUND;
      found_address   <= 32'd0;
      found_last_seen <= 32'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOCAL_ADDRESS: local_address <= cfg_data;
          REG_EXPIRY_LIMIT:  expiry_limit  <= cfg_data;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            launch_req.cmd  <= cmd_t'(command);
            launch_req.addr <= peer_address;
            launch_req.now  <= now;
            launch_req.pos  <= position;
            case (command) inside
              CMD_SEEN: begin
                if (peer_address == local_address) begin
                  // own address: answer at once, touch nothing
                  done            <= 1'b1;
                  launch_vld      <= 1'b0;
                  status          <= ST_SELF;
                  found_address   <= 32'd0;
                  found_last_seen <= 32'd0;
                  freed           <= '0;
                end else begin
                  done       <= 1'b0;
                  launch_vld <= 1'b1;
                  state      <= S_RUN;
                end
              end
              CMD_SWEEP, CMD_LOOKUP: begin
                done       <= 1'b0;
                launch_vld <= 1'b1;
                state      <= S_RUN;
              end
              default: begin
                // unused command: a lookup that finds nothing
                done            <= 1'b1;
                launch_vld      <= 1'b0;
                status          <= ST_NOT_FOUND;
                found_address   <= 32'd0;
                found_last_seen <= 32'd0;
                freed           <= '0;
              end
            endcase
          end else begin
            done       <= 1'b0;
            launch_vld <= 1'b0;
          end
        end
        S_RUN: begin
          launch_vld <= 1'b0;
          if (tok_vld[PEER_SLOTS]) begin
            state <= S_IDLE;
            done  <= 1'b1;
            case (tok[PEER_SLOTS].req.cmd)
              CMD_SEEN: begin
                found_address   <= 32'd0;
                found_last_seen <= 32'd0;
                freed           <= '0;
                if (tok[PEER_SLOTS].hit) begin
                  status <= ST_REFRESHED;
                end else if (tok[PEER_SLOTS].free_vld) begin
                  status <= ST_ADDED;
                  live   <= live + CW'(1);
                end else begin
                  status <= ST_FULL;
                end
              end
              CMD_SWEEP: begin
                found_address   <= 32'd0;
                found_last_seen <= 32'd0;
                status          <= ST_SWEPT;
                freed           <= tok_cnt[PEER_SLOTS];
                live            <= live - tok_cnt[PEER_SLOTS];
              end
              default: begin
                freed <= '0;
                if (tok[PEER_SLOTS].hit) begin
                  status          <= ST_FOUND;
                  found_address   <= tok[PEER_SLOTS].f_addr;
                  found_last_seen <= tok[PEER_SLOTS].f_seen;
                end else begin
                  status          <= ST_NOT_FOUND;
                  found_address   <= 32'd0;
                  found_last_seen <= 32'd0;
                end
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule
